[hw/rtl/plucked_string_delay_loop_assert.svh]
// Assertion macros for the checker of the string loop.
`ifndef PLUCKED_STRING_DELAY_LOOP_ASSERT_SVH
`define PLUCKED_STRING_DELAY_LOOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PSDL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PSDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pks_pkg.sv]
`timescale 1ns / 1ps

package pks_pkg;

	// Sample and filter state widths
	localparam int SAMPLE_W = 16;
	localparam int ACC_W    = 24;
	localparam int OPA_W    = 26;
	localparam int OPB_W    = 26;
	localparam int PROD_W   = OPA_W + OPB_W;

	// Request kinds carried on tuser
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_TICK    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_ADDR_W-1:0] REG_LOOP_LENGTH  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ALLPASS_COEF = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_LOWPASS_GAIN = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_LOOP_LOSS    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_BOW_GAIN     = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_VOICE_ACTIVE = 3'd5;

	// Post-multiply shift selection
	localparam logic [1:0] SH_8  = 2'd0;
	localparam logic [1:0] SH_15 = 2'd1;
	localparam logic [1:0] SH_22 = 2'd2;
	localparam logic [1:0] SH_24 = 2'd3;

	// DC blocker pole 0.997 in Q0.24, full scale and clamp limits
	localparam logic signed [OPA_W-1:0] DC_POLE     = 26'sd16726884;
	localparam logic signed [OPB_W-1:0] SAMPLE_FULL = 26'sd32767;
	localparam logic signed [ACC_W-1:0] CLAMP_HI    = 24'sd4194304;
	localparam logic signed [ACC_W-1:0] CLAMP_LO    = -24'sd4194304;

	// Control of the shared multiply, round and saturate unit
	typedef struct packed {
		logic [1:0] shift;
		logic       trunc;
		logic       neg;
	} mac_ctrl_t;

endpackage

[hw/rtl/plucked_string_delay_loop.sv]
`timescale 1ns / 1ps

// Plucked string loop: a circular delay line of Q1.15 samples with an allpass,
// a damping lowpass, a loop loss, a DC blocker and bow noise in the feedback.
// Input channel s_*: tuser holds the request kind (load, tick, restart);
// tdata holds load_index, load_value and noise. Output channel m_*: one
// sample per tick, none for load, restart or an unknown kind.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr;
// write only while no request is in flight and no result is waiting.
// A tick of an active voice runs seven multiply steps on the single shared
// multiplier, each through a multiply and an accumulate state, and then
// writes its sample to the output register. An inactive tick gives a zero
// sample. One request is in flight at a time.
// Reset clears the pointer, filter states and output valid, presets registers;
// the delay line holds no defined value until loaded and needs no clearing.
// When the receiver stalls, the result is held in the output register and
// the tick waits in its last step until the register is free.
module plucked_string_delay_loop
	import pks_pkg::*;
#(
	parameter int LINE_DEPTH = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,   // load_index[8:0], load_value[24:9], noise[40:25]
	input  logic [1:0]            s_tuser,   // mode[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // sample[15:0]
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int PTR_W = $clog2(LINE_DEPTH);
	localparam int LEN_W = (PTR_W + 1 > 9) ? PTR_W + 1 : 9;
	localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LINE_DEPTH);

	// Sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_ACC    = 3'd3;
	localparam logic [2:0] ST_WRITE  = 3'd4;
	localparam logic [2:0] ST_SILENT = 3'd5;

	// Steps on the shared unit
	localparam logic [2:0] OP_AP_OUT   = 3'd0;
	localparam logic [2:0] OP_AP_STATE = 3'd1;
	localparam logic [2:0] OP_LOWPASS  = 3'd2;
	localparam logic [2:0] OP_LOSS     = 3'd3;
	localparam logic [2:0] OP_DC       = 3'd4;
	localparam logic [2:0] OP_BOW      = 3'd5;
	localparam logic [2:0] OP_SCALE    = 3'd6;

	// Configuration registers
	logic [8:0]                 loop_length_q;
	logic signed [15:0]         allpass_coef_q;
	logic [14:0]                lowpass_gain_q;
	logic [23:0]                loop_loss_q;
	logic [14:0]                bow_gain_q;
	logic                       voice_active_q;

	// Sequencer and loop state
	logic [2:0]                 state_q;
	logic [2:0]                 op_q;
	logic [PTR_W-1:0]           ptr_q;
	logic signed [ACC_W-1:0]    y_q;
	logic signed [ACC_W-1:0]    ap_q;
	logic signed [ACC_W-1:0]    lp_q;
	logic signed [ACC_W-1:0]    dcx_q;
	logic signed [ACC_W-1:0]    dcy_q;
	logic signed [ACC_W-1:0]    tmp_q;

	// Held request
	logic [1:0]                 mode_q;
	logic [8:0]                 idx_q;
	logic [SAMPLE_W-1:0]        val_q;
	logic signed [SAMPLE_W-1:0] noise_q;

	// Output register
	logic                       m_tvalid_q;
	logic [15:0]                m_tdata_q;

	logic                       s_fire;
	logic                       out_free;
	logic                       emit_tick;
	logic                       emit_silent;
	logic [LEN_W-1:0]           len;
	logic [LEN_W-1:0]           ptr_inc;
	logic [PTR_W-1:0]           ptr_next;
	logic [LEN_W-1:0]           idx_ext;
	logic                       load_ok;

	logic                       ram_we;
	logic [PTR_W-1:0]           ram_waddr;
	logic [SAMPLE_W-1:0]        ram_wdata;
	logic                       ram_re;
	logic [SAMPLE_W-1:0]        ram_rdata;

	mac_ctrl_t                  mac_ctrl;
	logic signed [OPA_W-1:0]    mac_a;
	logic signed [OPB_W-1:0]    mac_b;
	logic signed [OPA_W-1:0]    mac_add;
	logic signed [ACC_W-1:0]    mac_res;

	logic signed [ACC_W-1:0]    x_s;
	logic signed [ACC_W:0]      diff;
	logic signed [ACC_W:0]      dc_in;
	logic signed [ACC_W-1:0]    clamp_v;
	logic signed [ACC_W:0]      y_rnd;
	logic signed [ACC_W:0]      y_sh;
	logic [15:0]                sample_v;

	assign s_tready    = (state_q == ST_IDLE);
	assign s_fire      = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign emit_tick   = (state_q == ST_WRITE) && out_free;
	assign emit_silent = (state_q == ST_SILENT) && out_free;
	assign m_tvalid    = m_tvalid_q;
	assign m_tdata     = m_tdata_q;

	// Wrap the pointer at the loop length, capped at the line depth
	always_comb begin
		len      = (LEN_W'(loop_length_q) > DEPTH_L) ? DEPTH_L : LEN_W'(loop_length_q);
		ptr_inc  = LEN_W'(ptr_q) + LEN_W'(1);
		ptr_next = (ptr_inc >= len) ? '0 : PTR_W'(ptr_inc);
		idx_ext  = LEN_W'(idx_q);
		load_ok  = (mode_q == MODE_LOAD) && (idx_ext < DEPTH_L);
	end

	// Delay line port selection
	always_comb begin
		ram_we    = ((state_q == ST_DECODE) && load_ok) || emit_tick;
		ram_waddr = (state_q == ST_DECODE) ? PTR_W'(idx_ext) : ptr_q;
		ram_wdata = (state_q == ST_DECODE) ? val_q : tmp_q[SAMPLE_W-1:0];
		ram_re    = (state_q == ST_DECODE) && (mode_q == MODE_TICK) && voice_active_q;
	end

	pks_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// Operands for the shared unit, one set per step
	always_comb begin
		x_s   = {{(ACC_W-SAMPLE_W-7){ram_rdata[SAMPLE_W-1]}}, ram_rdata, 7'b0};
		diff  = (ACC_W+1)'(y_q) - (ACC_W+1)'(lp_q);
		dc_in = (ACC_W+1)'(tmp_q) - (ACC_W+1)'(dcx_q);
		if (tmp_q > CLAMP_HI) begin
			clamp_v = CLAMP_HI;
		end else if (tmp_q < CLAMP_LO) begin
			clamp_v = CLAMP_LO;
		end else begin
			clamp_v = tmp_q;
		end
		mac_ctrl = '{shift: SH_15, trunc: 1'b0, neg: 1'b0};
		unique case (op_q)
			OP_AP_OUT: begin
				mac_a   = OPA_W'(allpass_coef_q);
				mac_b   = OPB_W'(x_s);
				mac_add = OPA_W'(ap_q);
			end
			OP_AP_STATE: begin
				mac_a        = OPA_W'(allpass_coef_q);
				mac_b        = OPB_W'(y_q);
				mac_add      = OPA_W'(x_s);
				mac_ctrl.neg = 1'b1;
			end
			OP_LOWPASS: begin
				mac_a   = OPA_W'(diff);
				mac_b   = OPB_W'(lowpass_gain_q);
				mac_add = OPA_W'(lp_q);
			end
			OP_LOSS: begin
				mac_a          = OPA_W'(lp_q);
				mac_b          = OPB_W'(loop_loss_q);
				mac_add        = '0;
				mac_ctrl.shift = SH_24;
			end
			OP_DC: begin
				mac_a          = DC_POLE;
				mac_b          = OPB_W'(dcy_q);
				mac_add        = OPA_W'(dc_in);
				mac_ctrl.shift = SH_24;
			end
			OP_BOW: begin
				mac_a          = OPA_W'(noise_q);
				mac_b          = OPB_W'(bow_gain_q);
				mac_add        = OPA_W'(dcy_q);
				mac_ctrl.shift = SH_8;
			end
			OP_SCALE: begin
				mac_a          = OPA_W'(clamp_v);
				mac_b          = SAMPLE_FULL;
				mac_add        = '0;
				mac_ctrl.shift = SH_22;
				mac_ctrl.trunc = 1'b1;
			end
			default: begin
				mac_a   = '0;
				mac_b   = '0;
				mac_add = '0;
			end
		endcase
	end

	pks_mac u_mac (
		.clk   (clk),
		.en    (state_q == ST_MUL),
		.ctrl  (mac_ctrl),
		.op_a  (mac_a),
		.op_b  (mac_b),
		.addend(mac_add),
		.res   (mac_res)
	);

	// Round the allpass output to Q1.15 and saturate
	always_comb begin
		y_rnd = (ACC_W+1)'(y_q) + (ACC_W+1)'(64);
		y_sh  = y_rnd >>> 7;
		if ((&y_sh[ACC_W:15]) || !(|y_sh[ACC_W:15])) begin
			sample_v = y_sh[15:0];
		end else if (y_sh[ACC_W]) begin
			sample_v = 16'h8000;
		end else begin
			sample_v = 16'h7FFF;
		end
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_length_q  <= 9'd4;
			allpass_coef_q <= '0;
			lowpass_gain_q <= 15'd32767;
			loop_loss_q    <= 24'd16777215;
			bow_gain_q     <= '0;
			voice_active_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_LOOP_LENGTH:  loop_length_q  <= cfg_wdata[8:0];
				REG_ALLPASS_COEF: allpass_coef_q <= cfg_wdata[15:0];
				REG_LOWPASS_GAIN: lowpass_gain_q <= cfg_wdata[14:0];
				REG_LOOP_LOSS:    loop_loss_q    <= cfg_wdata[23:0];
				REG_BOW_GAIN:     bow_gain_q     <= cfg_wdata[14:0];
				REG_VOICE_ACTIVE: voice_active_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Hold the request while it is worked on
	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_q  <= s_tuser;
			idx_q   <= s_tdata[8:0];
			val_q   <= s_tdata[24:9];
			noise_q <= s_tdata[40:25];
		end
	end

	// Sequence the steps and update the loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_AP_OUT;
			ptr_q   <= '0;
			y_q     <= '0;
			ap_q    <= '0;
			lp_q    <= '0;
			dcx_q   <= '0;
			dcy_q   <= '0;
			tmp_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					op_q <= OP_AP_OUT;
					if (mode_q == MODE_TICK) begin
						state_q <= voice_active_q ? ST_MUL : ST_SILENT;
					end else begin
						if (mode_q == MODE_RESTART) begin
							ptr_q <= '0;
							ap_q  <= '0;
							lp_q  <= '0;
							dcx_q <= '0;
							dcy_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					unique case (op_q)
						OP_AP_OUT:   y_q  <= mac_res;
						OP_AP_STATE: ap_q <= mac_res;
						OP_LOWPASS:  lp_q <= mac_res;
						OP_LOSS:     tmp_q <= mac_res;
						OP_DC: begin
							dcx_q <= tmp_q;
							dcy_q <= mac_res;
						end
						OP_BOW:      tmp_q <= mac_res;
						OP_SCALE:    tmp_q <= mac_res;
						default: ;
					endcase
					if (op_q == OP_SCALE) begin
						state_q <= ST_WRITE;
					end else begin
						op_q    <= op_q + 3'd1;
						state_q <= ST_MUL;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						ptr_q   <= ptr_next;
						state_q <= ST_IDLE;
					end
				end
				ST_SILENT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_tick || emit_silent) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_tick) begin
			m_tdata_q <= sample_v;
		end else if (emit_silent) begin
			m_tdata_q <= '0;
		end
	end

endmodule

[hw/rtl/pks_ram.sv]
`timescale 1ns / 1ps

module pks_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry into a register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/pks_mac.sv]
`timescale 1ns / 1ps

module pks_mac
	import pks_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  mac_ctrl_t               ctrl,
	input  logic signed [OPA_W-1:0] op_a,
	input  logic signed [OPB_W-1:0] op_b,
	input  logic signed [OPA_W-1:0] addend,
	output logic signed [ACC_W-1:0] res
);

	localparam logic signed [PROD_W:0] ONE = (PROD_W+1)'(1);

	logic signed [PROD_W-1:0] prod_q;
	logic signed [OPA_W-1:0]  addend_q;
	mac_ctrl_t                ctrl_q;

	logic [5:0]               sh_amt;
	logic signed [PROD_W:0]   prod_x;
	logic signed [PROD_W:0]   half;
	logic signed [PROD_W:0]   mask;
	logic signed [PROD_W:0]   bias;
	logic signed [PROD_W:0]   biased;
	logic signed [PROD_W:0]   rounded;
	logic signed [PROD_W+1:0] add_x;
	logic signed [PROD_W+1:0] rnd_x;
	logic signed [PROD_W+1:0] sum;
	logic [PROD_W+2-ACC_W:0]  upper;

	// Register the product and what goes with it
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q   <= op_a * op_b;
			addend_q <= addend;
			ctrl_q   <= ctrl;
		end
	end

	// Round or truncate toward zero, add or subtract, then saturate to the state width
	always_comb begin
		case (ctrl_q.shift)
			SH_8:    sh_amt = 6'd8;
			SH_15:   sh_amt = 6'd15;
			SH_22:   sh_amt = 6'd22;
			default: sh_amt = 6'd24;
		endcase
		prod_x  = {prod_q[PROD_W-1], prod_q};
		half    = ONE <<< (sh_amt - 6'd1);
		mask    = (ONE <<< sh_amt) - ONE;
		if (ctrl_q.trunc) begin
			bias = prod_q[PROD_W-1] ? mask : '0;
		end else begin
			bias = half;
		end
		biased  = prod_x + bias;
		rounded = biased >>> sh_amt;
		add_x   = (PROD_W+2)'(addend_q);
		rnd_x   = {rounded[PROD_W], rounded};
		sum     = ctrl_q.neg ? (add_x - rnd_x) : (add_x + rnd_x);
		upper   = sum[PROD_W+1:ACC_W-1];
		if ((&upper) || !(|upper)) begin
			res = sum[ACC_W-1:0];
		end else if (sum[PROD_W+1]) begin
			res = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

endmodule

[hw/rtl/pks_checker.sv]
`timescale 1ns / 1ps

`include "plucked_string_delay_loop_assert.svh"

module pks_checker
	import pks_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [15:0]           m_tdata,
	input logic                  cfg_we,
	input logic [CFG_ADDR_W-1:0] cfg_addr,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic voice_q;

	// Mirror the voice enable from the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_q <= 1'b0;
		end else if (cfg_we && (cfg_addr == REG_VOICE_ACTIVE)) begin
			voice_q <= cfg_wdata[0];
		end
	end

	// A taken request leaves the block busy in the next cycle
	`PSDL_ASSERT_NEXT(a_busy_after_request, clk, arst_n, s_tvalid && s_tready, !s_tready, "request taken but block still ready")

	// A fresh result comes only out of a busy period
	`PSDL_ASSERT_SAME(a_result_from_busy, clk, arst_n, m_tvalid && (!$past(m_tvalid) || $past(m_tready)), $past(!s_tready), "result appeared without work in flight")

	// An inactive voice renders silence
	`PSDL_ASSERT_SAME(a_silent_voice, clk, arst_n, m_tvalid && (!$past(m_tvalid) || $past(m_tready)) && !voice_q, m_tdata == 16'h0000, "inactive voice gave a non-zero sample")

	// Hold a stalled result
	`PSDL_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result dropped or changed")

endmodule

bind plucked_string_delay_loop pks_checker u_pks_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.cfg_we   (cfg_we),
	.cfg_addr (cfg_addr),
	.cfg_wdata(cfg_wdata)
);
